// ===== src/lfc_pkg.sv =====
// Package: payload types, constants and helpers for the log float converter.
`default_nettype none
package lfc_pkg;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_ENCODE = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [63:0] operand_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        overflow_flag;
    logic        underflow_flag;
  } out_item_t;

  localparam logic [31:0] LW_ZERO_WORD = 32'h4000_0000;
  localparam logic [31:0] LW_NEG_SAT   = 32'hFFC0_0000;
  localparam logic [31:0] LW_POS_SAT   = 32'h7FFF_FFFF;
  localparam int          LW_NEG_BIAS  = 104;
  localparam int          LW_POS_BIAS  = 151;

  // Stage 1 to stage 2 working set.
  typedef struct packed {
    logic        act;
    logic        neg;
    // decode
    logic [23:0] mag;
    logic [9:0]  scale;   // signed
    // encode
    logic        done;    // special result already known
    logic [31:0] word;
    logic        ovf;
    logic        unf;
    logic [52:0] mant;
    logic [5:0]  shift;
    logic [7:0]  expf;
  } s1_t;

  // Stage 2 to stage 3 working set.
  typedef struct packed {
    logic        act;
    logic        neg;
    logic        zero;
    logic [23:0] mag;
    logic [4:0]  top;
    logic [9:0]  scale;
    logic [31:0] word;
    logic        ovf;
    logic        unf;
  } s2_t;

  // Index of the highest set bit of a 24-bit value.
  function automatic logic [4:0] lead_one(input logic [23:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/lfc_unpack.sv =====
// Stage 1: field split, special-case classification and shift setup.
`default_nettype none
module lfc_unpack (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_v,
  input  wire lfc_pkg::in_item_t in_d,
  output logic                   s1_v_r,
  output lfc_pkg::s1_t           s1_r
);
  import lfc_pkg::*;

  s1_t        s1_nxt;
  logic [31:0] w;
  logic [7:0]  ef8;
  logic [10:0] ef;
  logic [51:0] mf;
  logic signed [11:0] e;

  always_comb begin
    w   = in_d.operand_bits[31:0];
    ef8 = w[30:23];
    ef  = in_d.operand_bits[62:52];
    mf  = in_d.operand_bits[51:0];
    e   = $signed({1'b0, ef}) - 12'sd1022;
    s1_nxt       = '0;
    s1_nxt.act   = in_d.action;
    s1_nxt.mant  = {1'b1, mf};
    if (in_d.action == ACT_DECODE) begin
      s1_nxt.neg = w[31];
      if (w[31]) begin
        s1_nxt.mag   = 24'h80_0000 - {1'b0, w[22:0]};
        s1_nxt.scale = 10'(LW_NEG_BIAS) - {2'b0, ef8};
      end else begin
        s1_nxt.mag   = {1'b0, w[22:0]};
        s1_nxt.scale = {2'b0, ef8} - 10'(LW_POS_BIAS);
      end
    end else begin
      s1_nxt.neg   = in_d.operand_bits[63];
      s1_nxt.shift = 6'd30;
      if (ef == 11'h7FF) begin
        s1_nxt.done = 1'b1;
        s1_nxt.ovf  = 1'b1;
        s1_nxt.word = (mf == '0 && in_d.operand_bits[63]) ? LW_NEG_SAT : LW_POS_SAT;
      end else if (ef == '0) begin
        s1_nxt.done = 1'b1;
        s1_nxt.unf  = (mf != '0);
        s1_nxt.word = LW_ZERO_WORD;
      end else if (e <= -12'sd151) begin
        s1_nxt.done = 1'b1;
        s1_nxt.unf  = 1'b1;
        s1_nxt.word = LW_ZERO_WORD;
      end else if (e > 12'sd127) begin
        s1_nxt.done = 1'b1;
        s1_nxt.ovf  = 1'b1;
        s1_nxt.word = in_d.operand_bits[63] ? LW_NEG_SAT : LW_POS_SAT;
      end else if (e < -12'sd128) begin
        s1_nxt.shift = 6'(12'sd30 - 12'sd128 - e);
        s1_nxt.expf  = in_d.operand_bits[63] ? 8'd255 : 8'd0;
      end else begin
        s1_nxt.expf = in_d.operand_bits[63] ? 8'(12'sd127 - e) : 8'(e + 12'sd128);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= in_v;
    s1_r <= s1_nxt;
  end
endmodule
`default_nettype wire

// ===== src/lfc_align.sv =====
// Stage 2: encode fraction shift and negate, decode leading-one search.
`default_nettype none
module lfc_align (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s1_v,
  input  wire lfc_pkg::s1_t s1,
  output logic              s2_v_r,
  output lfc_pkg::s2_t      s2_r
);
  import lfc_pkg::*;

  s2_t         s2_nxt;
  logic [22:0] sh;
  logic [22:0] q;

  always_comb begin
    sh = 23'(s1.mant >> s1.shift);
    q  = s1.neg ? 23'(23'd0 - sh) : sh;
    s2_nxt       = '0;
    s2_nxt.act   = s1.act;
    s2_nxt.neg   = s1.neg;
    s2_nxt.mag   = s1.mag;
    s2_nxt.zero  = (s1.mag == '0);
    s2_nxt.top   = lead_one(s1.mag);
    s2_nxt.scale = s1.scale;
    s2_nxt.ovf   = s1.ovf;
    s2_nxt.unf   = s1.unf;
    s2_nxt.word  = s1.done ? s1.word : {s1.neg, s1.expf, q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v;
    s2_r <= s2_nxt;
  end
endmodule
`default_nettype wire

// ===== src/lfc_pack.sv =====
// Stage 3: binary64 assembly for decode and result selection.
`default_nettype none
module lfc_pack (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s2_v,
  input  wire lfc_pkg::s2_t       s2,
  output logic                    out_v_r,
  output lfc_pkg::out_item_t      out_r
);
  import lfc_pkg::*;

  out_item_t   out_nxt;
  logic [10:0] bexp;
  logic [51:0] norm;

  always_comb begin
    bexp = 11'($signed({{1{s2.scale[9]}}, s2.scale}) + $signed({6'b0, s2.top}) + 11'sd1023);
    norm = 52'({28'b0, s2.mag} << (6'd52 - {1'b0, s2.top}));
    out_nxt = '0;
    if (s2.act == ACT_DECODE) begin
      out_nxt.result_bits = s2.zero ? 64'd0 : {s2.neg, bexp, norm};
    end else begin
      out_nxt.result_bits    = {32'd0, s2.word};
      out_nxt.overflow_flag  = s2.ovf;
      out_nxt.underflow_flag = s2.unf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= s2_v;
    out_r <= out_nxt;
  end
endmodule
`default_nettype wire

// ===== src/lis_float32_convert_unit.sv =====
// Top level: three-stage log float <-> binary64 converter.
// Path: start is registered through the unpack, align and pack stage registers to out_valid.
// Throughput: one item per cycle; busy is tied low since no stage ever holds.
// Stages: unpack/classify, fraction shift and leading-one search, pack.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none
module lis_float32_convert_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lfc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output lfc_pkg::out_item_t      out_item
);
  import lfc_pkg::*;

  logic s1_v, s2_v;
  s1_t  s1;
  s2_t  s2;

  // Every stage advances each cycle, so intake never stops.
  assign busy = 1'b0;

  lfc_unpack u_unpack (.clk, .rst_n, .in_v(start & ~busy), .in_d(in_item),
                       .s1_v_r(s1_v), .s1_r(s1));
  lfc_align  u_align  (.clk, .rst_n, .s1_v(s1_v), .s1(s1), .s2_v_r(s2_v), .s2_r(s2));
  lfc_pack   u_pack   (.clk, .rst_n, .s2_v(s2_v), .s2(s2), .out_v_r(out_valid),
                       .out_r(out_item));
endmodule
`default_nettype wire

// ===== src/lfc_checker.sv =====
// Checker: port-level properties of the converter, bound to the top level.
`default_nettype none
module lfc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire lfc_pkg::out_item_t out_item
);
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid) else $error("result missing");
  a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3)) else $error("spurious result");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.overflow_flag && out_item.underflow_flag))
    else $error("both flags");
  a_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.overflow_flag || out_item.underflow_flag))
      |-> out_item.result_bits[63:32] == 32'd0) else $error("encode upper bits");
endmodule

bind lis_float32_convert_unit lfc_checker u_lfc_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item);
`default_nettype wire
